// ----- hw/rtl/unsorted_priority_queue_macros.svh -----
// assertion macros for the unsorted priority queue
// no dependencies; included by the modules that carry assertions
`ifndef UNSORTED_PRIORITY_QUEUE_MACROS_SVH
`define UNSORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define UPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define UPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/upq_pkg.sv -----
// shared types and constants for the unsorted priority queue
// no dependencies; imported by every queue module
`default_nettype none

package upq_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ENTRY_W    = 2 * DATA_W;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } fsm_e;

  // one stored word: priority in the upper half
  typedef struct packed {
    logic [DATA_W-1:0] prio;
    logic [DATA_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/upq_ram.sv -----
// entry store: one write port, one read port with registered data
// depends on upq_pkg for the entry type
`default_nettype none

module upq_ram import upq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/upq_cmp.sv -----
// shared ranking unit: does a candidate entry beat the current best
// depends on upq_pkg for the entry type
`default_nettype none

module upq_cmp import upq_pkg::*; (
  input  entry_t cand_i,
  input  entry_t best_i,
  output logic   better_o
);

  logic prio_gt;
  logic prio_eq;
  logic value_gt;

  // signed priority first, then signed value; a full tie keeps the best
  assign prio_gt  = $signed(cand_i.prio) > $signed(best_i.prio);
  assign prio_eq  = cand_i.prio == best_i.prio;
  assign value_gt = $signed(cand_i.value) > $signed(best_i.value);
  assign better_o = prio_gt || (prio_eq && value_gt);

endmodule

`default_nettype wire

// ----- hw/rtl/unsorted_priority_queue.sv -----
// Unsorted priority queue: top level with sequencer, entry store and ranking unit.
// Enqueue, a dropped enqueue and a dequeue on empty: result strobe in the cycle after
// accept, next word taken after the response state; the receiver cannot stall.
// Dequeue of held entries: one pass through the store's single read port over the old
// slots, then the result strobe and the next word taken after the response state.
// Reset clears the held count and sets the limit to 16; the store is not cleared.
// depends on upq_pkg, upq_ram, upq_cmp and unsorted_priority_queue_macros.svh
`default_nettype none
`include "unsorted_priority_queue_macros.svh"

module unsorted_priority_queue import upq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic signed [DATA_W-1:0] entry_priority_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CAP_W-1:0]         cfg_data_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     is_empty_o,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic signed [DATA_W-1:0] top_priority_o,
  output logic [SLOT_OUT_W-1:0]    top_slot_o,
  output logic [COUNT_OUT_W-1:0]   entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  fsm_e            state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   scan_end_q, scan_end_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic            rd_vld_q;
  logic [AW-1:0]   rd_idx_q;
  logic [AW-1:0]   rm_slot_q, rm_slot_d;
  entry_t          top_q, top_d;
  logic [AW-1:0]   top_slot_q, top_slot_d;
  logic            best_vld_q, best_vld_d;
  status_e         status_q, status_d;

  logic            accept;
  logic [LW-1:0]   eff_limit;
  logic            full;
  entry_t          new_entry;
  entry_t          cand;
  logic            better;
  logic            issue;
  logic            keep;
  logic            shift_wr;
  logic [AW-1:0]   new_slot;
  logic            take;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  entry_t          rd_data;

  assign accept    = start && !busy;
  assign new_entry = '{prio: entry_priority_i, value: entry_value_i};

  // effective limit is the smaller of the register and the depth
  always_comb begin
    if (LW'(cap_q) > LW'(DEPTH)) begin
      eff_limit = LW'(DEPTH);
    end else begin
      eff_limit = LW'(cap_q);
    end
  end
  assign full = LW'(count_q) >= eff_limit;

  // scan pass: read old slots in order, skip the removed one, move later ones down
  assign issue    = (state_q == S_SCAN) && (ptr_q < scan_end_q);
  assign keep     = rd_vld_q && (rd_idx_q != rm_slot_q);
  assign shift_wr = rd_vld_q && (rd_idx_q > rm_slot_q);
  assign new_slot = shift_wr ? (rd_idx_q - AW'(1)) : rd_idx_q;

  // one comparator, fed by the incoming word or by the scanned entry
  assign cand = (state_q == S_SCAN) ? rd_data : new_entry;

  upq_cmp u_cmp (
    .cand_i   (cand),
    .best_i   (top_q),
    .better_o (better)
  );

  assign take = keep && (!best_vld_q || better);

  // store write port: append on enqueue, compaction during the scan
  always_comb begin
    if (state_q == S_SCAN) begin
      ram_we    = shift_wr;
      ram_waddr = new_slot;
      ram_wdata = rd_data;
    end else begin
      ram_we    = accept && (op_e'(opcode_i) == OP_ENQ) && !full;
      ram_waddr = count_q[AW-1:0];
      ram_wdata = new_entry;
    end
  end

  upq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (issue),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((op_e'(opcode_i) == OP_DEQ) && (count_q != '0)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (!issue && !rd_vld_q) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy   = state_q != S_IDLE;
    done_o = state_q == S_RESP;
  end

  // operation datapath
  always_comb begin
    count_d    = count_q;
    scan_end_d = scan_end_q;
    ptr_d      = ptr_q;
    best_vld_d = best_vld_q;
    status_d   = status_q;
    top_d      = top_q;
    top_slot_d = top_slot_q;
    rm_slot_d  = rm_slot_q;
    if (accept) begin
      if (op_e'(opcode_i) == OP_DEQ) begin
        if (count_q == '0) begin
          status_d = STS_EMPTY;
        end else begin
          status_d   = STS_DONE;
          count_d    = count_q - CW'(1);
          scan_end_d = count_q;
          ptr_d      = '0;
          best_vld_d = 1'b0;
          rm_slot_d  = top_slot_q;
        end
      end else if (full) begin
        status_d = STS_FULL;
      end else begin
        status_d = STS_DONE;
        count_d  = count_q + CW'(1);
        if ((count_q == '0) || better) begin
          top_d      = new_entry;
          top_slot_d = count_q[AW-1:0];
        end
      end
    end
    if (issue) begin
      ptr_d = ptr_q + CW'(1);
    end
    if (take) begin
      top_d      = rd_data;
      top_slot_d = new_slot;
      best_vld_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cap_q    <= CAP_RESET;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= issue;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_end_q <= scan_end_d;
    ptr_q      <= ptr_d;
    rd_idx_q   <= ptr_q[AW-1:0];
    rm_slot_q  <= rm_slot_d;
    top_q      <= top_d;
    top_slot_q <= top_slot_d;
    best_vld_q <= best_vld_d;
    status_q   <= status_d;
  end

  assign cfg_ready_o = 1'b1;

  // result word: zeros for the top entry when nothing is held
  assign status_o       = status_q;
  assign is_empty_o     = count_q == '0;
  assign top_value_o    = is_empty_o ? '0 : $signed(top_q.value);
  assign top_priority_o = is_empty_o ? '0 : $signed(top_q.prio);
  assign top_slot_o     = is_empty_o ? '0 : SLOT_OUT_W'(top_slot_q);
  assign entry_count_o  = COUNT_OUT_W'(count_q);

  // checks on the sequencer and the scan
  `UPQ_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH), "held count above depth")
  `UPQ_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "not busy after accept")
  `UPQ_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `UPQ_ASSERT_IMPL(a_scan_range, clk_i, rst_ni, rd_vld_q, CW'(rd_idx_q) < scan_end_q, "scan read outside old entries")
  `UPQ_ASSERT_IMPL(a_top_in_range, clk_i, rst_ni, (state_q == S_IDLE) && (count_q != '0), CW'(top_slot_q) < count_q, "top slot outside held entries")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking bench for unsorted_priority_queue: directed table, then random phases
// predicts each untyped result word in a local copy of the queue; depends on upq_pkg and unsorted_priority_queue
`default_nettype none

module tb_top import upq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 150;
  localparam logic signed [DATA_W-1:0] WMIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WMAX = 32'sh7fff_ffff;

  // one result word as the block reports it
  typedef struct packed {
    status_e                  status;
    logic                     is_empty;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic [SLOT_OUT_W-1:0]    slot;
    logic [COUNT_OUT_W-1:0]   count;
  } top_word_t;

  // one row of the directed table: a limit write or an operation
  typedef struct packed {
    logic                     is_cfg;
    logic [CAP_W-1:0]         limit;
    op_e                      op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic                     typed;
    top_word_t                want;
  } row_t;

  localparam top_word_t NO_WANT = '{STS_DONE, 1'b0, 32'sd0, 32'sd0, 4'd0, 5'd0};
  localparam top_word_t EMPTY_WANT = '{STS_EMPTY, 1'b1, 32'sd0, 32'sd0, 4'd0, 5'd0};
  localparam int unsigned PLAN_ROWS = 23;

  // directed table: extremes, ties, limit corner cases
  row_t plan [0:PLAN_ROWS-1] = '{
    // dequeue straight after reset
    '{1'b0, 5'd0, OP_DEQ, 32'sd0, 32'sd0, 1'b1, EMPTY_WANT},
    // first slot is a candidate at the minimum priority
    '{1'b0, 5'd0, OP_ENQ, WMIN, WMIN, 1'b1, '{STS_DONE, 1'b0, WMIN, WMIN, 4'd0, 5'd1}},
    // equal priority, larger value wins
    '{1'b0, 5'd0, OP_ENQ, 32'sd5, WMIN, 1'b1, '{STS_DONE, 1'b0, 32'sd5, WMIN, 4'd1, 5'd2}},
    // full tie, earlier slot wins
    '{1'b0, 5'd0, OP_ENQ, 32'sd5, WMIN, 1'b1, '{STS_DONE, 1'b0, 32'sd5, WMIN, 4'd1, 5'd3}},
    '{1'b0, 5'd0, OP_ENQ, WMAX, WMAX, 1'b1, '{STS_DONE, 1'b0, WMAX, WMAX, 4'd3, 5'd4}},
    '{1'b0, 5'd0, OP_ENQ, -32'sd1, -32'sd1, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_DEQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    // limit lowered below the held count
    '{1'b1, 5'd2, OP_ENQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_ENQ, 32'sd7, 32'sd7, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_DEQ, WMAX, WMAX, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_DEQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_DEQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_ENQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_ENQ, WMAX, WMIN, 1'b0, NO_WANT},
    // limit zero drops every enqueue
    '{1'b1, 5'd0, OP_ENQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_ENQ, 32'sd1, 32'sd1, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_DEQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_DEQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_DEQ, -32'sd1, -32'sd1, 1'b1, EMPTY_WANT},
    // limit above the store size
    '{1'b1, 5'd31, OP_ENQ, 32'sd0, 32'sd0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_ENQ, -32'sd1, WMAX, 1'b0, NO_WANT},
    '{1'b0, 5'd0, OP_ENQ, WMAX, -32'sd1, 1'b0, NO_WANT},
    '{1'b1, 5'd16, OP_ENQ, 32'sd0, 32'sd0, 1'b0, NO_WANT}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     opcode_i;
  logic signed [DATA_W-1:0] entry_value_i;
  logic signed [DATA_W-1:0] entry_priority_i;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CAP_W-1:0]         cfg_data_i;
  logic                     done_o;
  logic [STATUS_W-1:0]      status_o;
  logic                     is_empty_o;
  logic signed [DATA_W-1:0] top_value_o;
  logic signed [DATA_W-1:0] top_priority_o;
  logic [SLOT_OUT_W-1:0]    top_slot_o;
  logic [COUNT_OUT_W-1:0]   entry_count_o;

  // local copy of the queue
  logic signed [DATA_W-1:0] held_value [SLOTS];
  logic signed [DATA_W-1:0] held_prio  [SLOTS];
  int unsigned              held_n;
  logic [CAP_W-1:0]         cap_limit;

  top_word_t   pending_tops [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          steady;

  unsorted_priority_queue #(.DEPTH(SLOTS)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .entry_value_i    (entry_value_i),
    .entry_priority_i (entry_priority_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .is_empty_o       (is_empty_o),
    .top_value_o      (top_value_o),
    .top_priority_o   (top_priority_o),
    .top_slot_o       (top_slot_o),
    .entry_count_o    (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // linear scan: highest priority, then larger value, then earlier slot
  function automatic int unsigned best_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < held_n; i++) begin
      if (held_prio[i] > held_prio[best] ||
          (held_prio[i] == held_prio[best] && held_value[i] > held_value[best]))
        best = i;
    end
    return best;
  endfunction

  // apply one operation to the local queue and give the word it reports
  function automatic top_word_t apply_queue_op(op_e op, logic signed [DATA_W-1:0] value,
                                               logic signed [DATA_W-1:0] prio);
    top_word_t   r;
    int unsigned room;
    int unsigned t;
    room = (cap_limit > SLOTS) ? SLOTS : cap_limit;
    r = NO_WANT;
    if (op == OP_ENQ) begin
      if (held_n >= room) begin
        r.status = STS_FULL;
      end else begin
        held_value[held_n] = value;
        held_prio[held_n]  = prio;
        held_n++;
      end
    end else if (held_n == 0) begin
      r.status = STS_EMPTY;
    end else begin
      // close the gap left by the removed entry
      for (int unsigned i = best_slot(); i + 1 < held_n; i++) begin
        held_value[i] = held_value[i+1];
        held_prio[i]  = held_prio[i+1];
      end
      held_n--;
    end
    if (held_n == 0) begin
      r.is_empty = 1'b1;
    end else begin
      t       = best_slot();
      r.value = held_value[t];
      r.prio  = held_prio[t];
      r.slot  = t[SLOT_OUT_W-1:0];
    end
    r.count = held_n[COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("[%0t] %s: got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // random idle cycles before a word, none in a steady stretch
  task automatic idle_gap();
    if (!steady) begin
      while ($urandom_range(99) < 25) begin
        start = 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  // present one operation word; entered and left at a falling edge
  task automatic send_op(op_e op, logic signed [DATA_W-1:0] value,
                         logic signed [DATA_W-1:0] prio, logic typed, top_word_t want);
    top_word_t predicted;
    idle_gap();
    start            = 1'b1;
    opcode_i         = op;
    entry_value_i    = value;
    entry_priority_i = prio;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predicted = apply_queue_op(op, value, prio);
    pending_tops.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // limit write, only once every result word is back
  task automatic write_limit(logic [CAP_W-1:0] limit);
    start = 1'b0;
    while (pending_tops.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    idle_gap();
    cfg_valid_i = 1'b1;
    cfg_data_i  = limit;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cap_limit = limit;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // operand mix: extremes, a narrow band for ties, full range
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return WMIN;
      1:       return WMAX;
      2:       return -32'sd1;
      3, 4, 5: return DATA_W'($urandom_range(6)) - 32'sd3;
      default: return $urandom;
    endcase
  endfunction

  // result word check against the oldest expectation
  always @(posedge clk_i) begin
    top_word_t w;
    if (rst_ni && done_o) begin
      if (pending_tops.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        w = pending_tops.pop_front();
        if (status_o !== w.status)
          report_mismatch("status", DATA_W'(status_o), DATA_W'(w.status));
        if (is_empty_o !== w.is_empty)
          report_mismatch("is_empty", DATA_W'(is_empty_o), DATA_W'(w.is_empty));
        if (top_value_o !== w.value) report_mismatch("top_value", top_value_o, w.value);
        if (top_priority_o !== w.prio) report_mismatch("top_priority", top_priority_o, w.prio);
        if (top_slot_o !== w.slot)
          report_mismatch("top_slot", DATA_W'(top_slot_o), DATA_W'(w.slot));
        if (entry_count_o !== w.count)
          report_mismatch("entry_count", DATA_W'(entry_count_o), DATA_W'(w.count));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("unsorted_priority_queue: mismatch");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [CAP_W-1:0] phase_limit;
    int unsigned      left;
    int unsigned      burst;
    op_e              op;
    rst_ni           = 1'b0;
    start            = 1'b0;
    opcode_i         = OP_ENQ;
    entry_value_i    = '0;
    entry_priority_i = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    mismatches       = 0;
    cycles           = 0;
    steady           = 1'b0;
    held_n           = 0;
    cap_limit        = CAP_RESET;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    for (int unsigned r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].is_cfg) write_limit(plan[r].limit);
      else send_op(plan[r].op, plan[r].value, plan[r].prio, plan[r].typed, plan[r].want);
    end

    // random phases, each under its own limit, in bursts that fill and drain
    for (int unsigned ph = 0; ph < 11; ph++) begin
      case (ph)
        0:       phase_limit = 5'd1;
        1:       phase_limit = 5'd16;
        2:       phase_limit = 5'd31;
        3:       phase_limit = 5'd0;
        4:       phase_limit = 5'd2;
        6:       phase_limit = 5'd17;
        8:       phase_limit = 5'd16;
        default: phase_limit = CAP_W'($urandom_range(31));
      endcase
      write_limit(phase_limit);
      steady = (ph == 1 || ph == 2);
      left = PHASE_WORDS;
      while (left > 0) begin
        op    = $urandom_range(1) ? OP_DEQ : OP_ENQ;
        burst = (op == OP_ENQ) ? $urandom_range(20, 1) : $urandom_range(18, 1);
        if (burst > left) burst = left;
        repeat (burst) send_op(op, pick_word(), pick_word(), 1'b0, NO_WANT);
        left -= burst;
      end
    end
    start  = 1'b0;
    steady = 1'b0;

    // drain, then let the block settle
    while (pending_tops.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("unsorted_priority_queue: match");
    end else begin
      $display("unsorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- unsorted_priority_queue.f -----
+incdir+hw/rtl
hw/rtl/upq_pkg.sv
hw/rtl/upq_ram.sv
hw/rtl/upq_cmp.sv
hw/rtl/unsorted_priority_queue.sv
dv/tb_top.sv
